>>> src/teru_pkg.sv
// ----------------------------------------------------------------------------
// teru_pkg
// Shared types, codes and helpers of the trap entry and return unit.
// ----------------------------------------------------------------------------
package teru_pkg;

	localparam int unsigned XLEN = 64;

	// Request operation codes
	typedef enum logic [1:0] {
		OP_TRAP  = 2'd0,
		OP_MRET  = 2'd1,
		OP_SRET  = 2'd2,
		OP_UNSUP = 2'd3
	} op_t;

	// Result error codes
	typedef enum logic [1:0] {
		ERR_OK           = 2'd0,
		ERR_SRET_TRAPPED = 2'd1,
		ERR_UNSUPPORTED  = 2'd2,
		ERR_BAD_LEVEL    = 2'd3
	} err_t;

	// Privilege levels (2 is reserved)
	localparam logic [1:0] PRIV_U   = 2'd0;
	localparam logic [1:0] PRIV_S   = 2'd1;
	localparam logic [1:0] PRIV_RSV = 2'd2;
	localparam logic [1:0] PRIV_M   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_MTVEC = 2'd0;
	localparam logic [1:0] CFG_SEPC  = 2'd1;
	localparam logic [1:0] CFG_TSR   = 2'd2;

	// Fault kinds
	localparam logic [2:0] FAULT_ECALL       = 3'd0;
	localparam logic [2:0] FAULT_ILLEGAL     = 3'd1;
	localparam logic [2:0] FAULT_LOAD        = 3'd2;
	localparam logic [2:0] FAULT_LOAD_ALIGN  = 3'd3;
	localparam logic [2:0] FAULT_STORE       = 3'd4;
	localparam logic [2:0] FAULT_STORE_ALIGN = 3'd5;
	localparam logic [2:0] FAULT_FETCH       = 3'd6;
	localparam logic [2:0] FAULT_FETCH_ALIGN = 3'd7;

	typedef struct packed {
		logic [1:0]      operation;
		logic [2:0]      fault_kind;
		logic            is_interrupt;
		logic [XLEN-1:0] current_pc;
		logic [XLEN-1:0] fault_address;
	} req_t;

	typedef struct packed {
		logic [1:0]      error_code;
		logic [XLEN-1:0] next_pc;
		logic [1:0]      new_level;
		logic            interrupts_enabled;
		logic [XLEN-1:0] recorded_cause;
	} rsp_t;

	typedef struct packed {
		logic [1:0]      index;
		logic [XLEN-1:0] data;
	} cfg_t;

	// Configuration register contents handed to the core
	typedef struct packed {
		logic [XLEN-1:0] mtvec;
		logic [XLEN-1:0] sepc;
		logic            tsr;
	} cfg_regs_t;

	// Status bits, MSB first: MPP, SPP, MPIE, SPIE, MIE, SIE
	typedef struct packed {
		logic [1:0] mpp;
		logic       spp;
		logic       mpie;
		logic       spie;
		logic       mie;
		logic       sie;
	} status_t;

	// Exception cause code; ecall gives 8 plus the current level
	function automatic logic [3:0] cause_code(input logic [2:0] kind, input logic [1:0] lvl);
		logic [3:0] code;
		unique case (kind)
			FAULT_ECALL:       code = 4'd8 + {2'b00, lvl};
			FAULT_ILLEGAL:     code = 4'd2;
			FAULT_LOAD:        code = 4'd5;
			FAULT_LOAD_ALIGN:  code = 4'd4;
			FAULT_STORE:       code = 4'd7;
			FAULT_STORE_ALIGN: code = 4'd6;
			FAULT_FETCH:       code = 4'd1;
			FAULT_FETCH_ALIGN: code = 4'd0;
			default:           code = 4'd0;
		endcase
		return code;
	endfunction

endpackage

>>> src/teru_chan_if.sv
// ----------------------------------------------------------------------------
// teru_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface teru_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> src/trap_entry_and_return_unit.sv
// ----------------------------------------------------------------------------
// trap_entry_and_return_unit
// RV64 machine trap entry with MRET / SRET return handling.
// ----------------------------------------------------------------------------
// Each request (trap entry, MRET, SRET or an unsupported code) gives exactly
// one result. Throughput is one request per clock while the output buffer has
// room. The request is captured in an input register; from there the trap core
// computes the state update and the result combinationally, and they land in
// a two-entry output buffer once it has room. The buffer's output register
// offers the result to the response channel.
// The status bits, privilege level, EPC, cause and trap value update at the
// same edge the result enters the buffer, so back-to-back requests see each
// other's effects in order. Requests keep flowing while a result waits on the
// output; the buffer only pushes back once two results are pending, and then
// a third request waits in the input register. Configuration writes (trap
// vector, supervisor return PC, TSR) are always ready and should only be
// issued when no request is in flight.
// ----------------------------------------------------------------------------
module trap_entry_and_return_unit (
	input  logic        clk,
	input  logic        arst_n,
	teru_chan_if.sink   req,
	teru_chan_if.source rsp,
	teru_chan_if.sink   cfg
);

	// Input stage
	logic                valid_s1;
	teru_pkg::req_t      req_s1;
	logic                req_xfer;
	logic                fire_s1;

	// Core / buffer hookup
	teru_pkg::cfg_regs_t cfg_regs;
	teru_pkg::rsp_t      result;
	logic                obuf_ready;

	// Config port never stalls
	assign cfg.ready = 1'b1;

	teru_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg.valid),
		.wr     (cfg.payload),
		.regs   (cfg_regs)
	);

	// Input register: refill whenever it empties or moves on this cycle
	assign fire_s1   = valid_s1 && obuf_ready;
	assign req.ready = !valid_s1 || obuf_ready;
	assign req_xfer  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_s1 <= req.payload;
		end
	end

	// Trap state commits only when the result is accepted by the buffer
	teru_trap_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (fire_s1),
		.req    (req_s1),
		.cfg    (cfg_regs),
		.rsp    (result)
	);

	teru_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire_s1),
		.din       (result),
		.in_ready  (obuf_ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.dout      (rsp.payload)
	);

endmodule

>>> src/teru_cfg_regs.sv
// ----------------------------------------------------------------------------
// teru_cfg_regs
// Trap vector, supervisor return PC and TSR configuration registers.
// ----------------------------------------------------------------------------
module teru_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  teru_pkg::cfg_t        wr,
	output teru_pkg::cfg_regs_t   regs
);

	teru_pkg::cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (wr_en) begin
			unique case (wr.index)
				teru_pkg::CFG_MTVEC: regs_q.mtvec <= wr.data;
				teru_pkg::CFG_SEPC:  regs_q.sepc  <= wr.data;
				teru_pkg::CFG_TSR:   regs_q.tsr   <= wr.data[0];
				default:             regs_q       <= regs_q;  // unmapped index
			endcase
		end
	end

	assign regs = regs_q;

endmodule

>>> src/teru_trap_core.sv
// ----------------------------------------------------------------------------
// teru_trap_core
// Architectural trap state and the combinational trap / return update.
// ----------------------------------------------------------------------------
module teru_trap_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  teru_pkg::req_t      req,
	input  teru_pkg::cfg_regs_t cfg,
	output teru_pkg::rsp_t      rsp
);

	logic [1:0]                  level_q;
	teru_pkg::status_t           status_q;
	logic [teru_pkg::XLEN-1:0]   mepc_q;
	logic [teru_pkg::XLEN-1:0]   mcause_q;
	logic [teru_pkg::XLEN-1:0]   mtval_q;

	logic [1:0]                  level_d;
	teru_pkg::status_t           status_d;
	logic [teru_pkg::XLEN-1:0]   mepc_d;
	logic [teru_pkg::XLEN-1:0]   mcause_d;
	logic [teru_pkg::XLEN-1:0]   mtval_d;

	teru_pkg::op_t               op;
	logic [3:0]                  code;
	logic [teru_pkg::XLEN-1:0]   base;
	logic [teru_pkg::XLEN-1:0]   target;
	logic                        bad_level;

	assign op        = teru_pkg::op_t'(req.operation);
	assign code      = teru_pkg::cause_code(req.fault_kind, level_q);
	assign base      = {cfg.mtvec[teru_pkg::XLEN-1:2], 2'b00};
	// vectored mode offsets interrupts by 4 * cause
	assign target    = (cfg.mtvec[0] && req.is_interrupt) ?
	                   base + {{(teru_pkg::XLEN-6){1'b0}}, code, 2'b00} : base;
	assign bad_level = (level_q == teru_pkg::PRIV_U) || (level_q == teru_pkg::PRIV_RSV);

	always_comb begin
		level_d  = level_q;
		status_d = status_q;
		mepc_d   = mepc_q;
		mcause_d = mcause_q;
		mtval_d  = mtval_q;
		rsp      = '0;
		rsp.error_code = teru_pkg::ERR_OK;
		unique case (op)
			teru_pkg::OP_TRAP: begin
				mcause_d        = {req.is_interrupt, {(teru_pkg::XLEN-5){1'b0}}, code};
				mepc_d          = req.current_pc;
				mtval_d         = req.fault_address;
				status_d.mpie   = status_q.mie;
				status_d.mie    = 1'b0;
				status_d.mpp    = level_q;
				level_d         = teru_pkg::PRIV_M;
				rsp.next_pc     = target;
			end
			teru_pkg::OP_UNSUP: begin
				rsp.error_code = teru_pkg::ERR_UNSUPPORTED;
			end
			teru_pkg::OP_MRET: begin
				if (bad_level) begin
					rsp.error_code = teru_pkg::ERR_BAD_LEVEL;
				end else begin
					level_d                = status_q.mpp;
					status_d.mie           = status_q.mpie;
					status_d.mpie          = 1'b1;
					status_d.mpp           = teru_pkg::PRIV_U;
					rsp.next_pc            = mepc_q;
					rsp.interrupts_enabled = status_q.mpie;
				end
			end
			teru_pkg::OP_SRET: begin
				// TSR refusal takes priority over the level check
				if (cfg.tsr) begin
					rsp.error_code = teru_pkg::ERR_SRET_TRAPPED;
				end else if (bad_level) begin
					rsp.error_code = teru_pkg::ERR_BAD_LEVEL;
				end else begin
					level_d                = {1'b0, status_q.spp};
					status_d.sie           = status_q.spie;
					status_d.spie          = 1'b1;
					status_d.spp           = 1'b0;
					rsp.next_pc            = cfg.sepc;
					rsp.interrupts_enabled = status_q.spie;
				end
			end
			default: begin
				rsp.error_code = teru_pkg::ERR_UNSUPPORTED;
			end
		endcase
		rsp.new_level      = level_d;
		rsp.recorded_cause = mcause_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= teru_pkg::PRIV_M;
			status_q <= '0;
			mepc_q   <= '0;
			mcause_q <= '0;
			mtval_q  <= '0;
		end else if (commit) begin
			level_q  <= level_d;
			status_q <= status_d;
			mepc_q   <= mepc_d;
			mcause_q <= mcause_d;
			mtval_q  <= mtval_d;
		end
	end

endmodule

>>> src/teru_out_buf.sv
// ----------------------------------------------------------------------------
// teru_out_buf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module teru_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  teru_pkg::rsp_t din,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output teru_pkg::rsp_t dout
);

	logic [1:0]     count_q;
	teru_pkg::rsp_t head_q;
	teru_pkg::rsp_t spare_q;
	logic           pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign dout      = head_q;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (count_q == 2'd1) begin
				head_q <= din;
			end else begin
				head_q  <= spare_q;
				spare_q <= din;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				head_q <= din;
			end else begin
				spare_q <= din;
			end
		end else if (pop) begin
			head_q <= spare_q;
		end
	end

endmodule
